// ===== sv/pcfwrl_pkg.sv =====
`default_nettype none

package pcfwrl_pkg;

  localparam int KEY_W   = 32;
  localparam int TIME_W  = 40;
  localparam int WIN_W   = 32;
  localparam int COUNT_W = 16;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS = 1'd1;

  localparam logic [WIN_W-1:0]   WINDOW_MS_RESET    = 32'd60000;
  localparam logic [COUNT_W-1:0] MAX_REQUESTS_RESET = 16'd100;

  typedef struct packed {
    logic [KEY_W-1:0]  client_key;
    logic [TIME_W-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic               allowed;
    logic               table_full;
    logic [COUNT_W-1:0] count_now;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [TIME_W-1:0]  win_origin;
    logic [COUNT_W-1:0] count;
  } slot_t;

endpackage

`default_nettype wire

// ===== sv/pcfwrl_window_unit.sv =====
`default_nettype none

module pcfwrl_window_unit
  import pcfwrl_pkg::*;
(
  input  wire logic [TIME_W-1:0] now_ms,
  input  wire logic [TIME_W-1:0] win_origin,
  input  wire logic [WIN_W-1:0]  window_ms,
  output logic                   expired
);

  logic [TIME_W-1:0] elapsed;

  // A timestamp at or before the window start never expires the window.
  always_comb begin
    elapsed = now_ms - win_origin;
    expired = (now_ms > win_origin) &&
              (elapsed > {{(TIME_W-WIN_W){1'b0}}, window_ms});
  end

endmodule

`default_nettype wire

// ===== sv/per_client_fixed_window_rate_limiter.sv =====
`default_nettype none

// Channel    Handshake            Payload
// request    start, busy          req (client_key, now_ms)
// result     done (strobe)        result (allowed, table_full, count_now)
// config     cfg_we               cfg_index, cfg_data
//
// A request that hits a slot, or claims a free slot, passes from the walk through
// the window check and then the count update before the done strobe; a full
// table answers straight from the walk without an update.
// The walk reads one slot per cycle from the slot memory, and the window check
// and the count update are separate states (S_EXPIRE, then S_FINISH).
// Synchronous reset clears the valid bits and restores the register defaults.
// Busy is high until the result is written; results are strobed for one cycle
// and the receiver cannot stall them.

module per_client_fixed_window_rate_limiter
  import pcfwrl_pkg::*;
#(
  parameter int SLOTS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire req_t                 req,
  output logic                      done,
  output rsp_t                      result,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOTS);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_EXPIRE = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;

  logic [WIN_W-1:0]   window_ms;
  logic [COUNT_W-1:0] max_requests;

  logic [SLOTS-1:0] slot_valid;
  slot_t            slot_mem [SLOTS];
  slot_t            rd_q;

  req_t             req_q;
  slot_t            cur;
  logic [IDX_W-1:0] hit_idx;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] cnt_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_vld;
  logic             hit_cmp;
  logic             rd_en;
  logic             expired;
  logic [COUNT_W-1:0] count_inc;

  assign cnt_idx = cnt[IDX_W-1:0];
  assign busy    = (state != S_IDLE);

  pcfwrl_window_unit u_window (
    .now_ms     (req_q.now_ms),
    .win_origin (cur.win_origin),
    .window_ms  (window_ms),
    .expired    (expired)
  );

  always_comb begin
    hit_cmp   = cmp_vld && (rd_q.key == req_q.client_key);
    rd_en     = (state == S_SCAN) && !hit_cmp && (cnt != LAST_CNT) && slot_valid[cnt_idx];
    count_inc = (cur.count == COUNT_MAX) ? cur.count : cur.count + COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms    <= WINDOW_MS_RESET;
      max_requests <= MAX_REQUESTS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_MS:    window_ms    <= cfg_data[WIN_W-1:0];
        REG_MAX_REQUESTS: max_requests <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= slot_mem[cnt_idx];
    end
    if (state == S_FINISH) begin
      slot_mem[hit_idx] <= '{key: cur.key, win_origin: cur.win_origin,
                             count: count_inc};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      done       <= 1'b0;
      cmp_vld    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_q   <= req;
            cnt     <= '0;
            cmp_vld <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit_cmp) begin
            cur     <= rd_q;
            hit_idx <= cmp_idx;
            state   <= S_EXPIRE;
          end else if (cnt == LAST_CNT) begin
            result <= '{allowed: 1'b1, table_full: 1'b1, count_now: '0};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (!slot_valid[cnt_idx]) begin
            cur     <= '{key: req_q.client_key, win_origin: req_q.now_ms, count: '0};
            hit_idx <= cnt_idx;
            state   <= S_EXPIRE;
          end else begin
            cmp_vld <= 1'b1;
            cmp_idx <= cnt_idx;
            cnt     <= cnt + CNT_W'(1);
          end
        end
        S_EXPIRE: begin
          if (expired) begin
            cur.win_origin <= req_q.now_ms;
            cur.count      <= '0;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          slot_valid[hit_idx] <= 1'b1;
          result <= '{allowed: (count_inc <= max_requests), table_full: 1'b0,
                      count_now: count_inc};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_FINISH) || ($past(state) == S_SCAN))
    else $error("done strobe without a finishing request");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (done && result.table_full) |-> (result.allowed && (result.count_now == '0)))
    else $error("table full result has wrong fields");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.table_full) |-> (result.count_now != '0))
    else $error("counted request reports zero count");

  a_valid_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> ((slot_valid & $past(slot_valid)) == $past(slot_valid)))
    else $error("slot valid bit was cleared");

endmodule

`default_nettype wire
